// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/dtp_pkg.sv -----
`default_nettype none

package dtp_pkg;

  // Default sizing of the tree and the observation
  localparam int unsigned DefMaxRows       = 64;
  localparam int unsigned DefModerators    = 4;
  localparam int unsigned DefCategoryLevels = 16;
  localparam int unsigned DefValueBits     = 32;

  // Request kinds
  localparam logic KindLoad      = 1'b0;
  localparam logic KindPartition = 1'b1;

  // Node codes
  localparam logic [6:0] NodeNa   = 7'd0;
  localparam logic [6:0] NodeRoot = 7'd1;

  typedef struct packed {
    logic              kind;
    logic [5:0]        row_index;
    logic [6:0]        parent_node;
    logic              numeric_split;
    logic [1:0]        moderator_select;
    logic signed [31:0] threshold;
    logic [15:0]       split_categories;
    logic [15:0]       known_categories;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
  } in_t;

  typedef struct packed {
    logic [5:0] tree_row;
    logic [6:0] node_number;
    logic       last;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } dtp_state_e;

endpackage

`default_nettype wire

// ----- rtl/dtp_ram.sv -----
`default_nettype none

module dtp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/decision_tree_partition.sv -----
// Binary decision tree partition. A request with kind 0 stores one split row
// and gives no result; busy stays low. A request with kind 1 walks the
// observation through rows 0 .. row_count-1 and gives one result per row on
// consecutive cycles, the first in the cycle after start is taken; busy stays
// high until the last row is evaluated (never for a one-row tree), and the
// next request is taken only once busy is low again. The rate is set by the
// single evaluation unit that handles one row a cycle from the row memory,
// whose next row is read while the current one is evaluated. Results are
// shown with valid_o for one cycle each and cannot be stalled; a node of 0
// marks an unknown category and stays 0 for the rest of the walk. Write
// row_count only while busy is low.
`default_nettype none

module decision_tree_partition #(
  parameter int unsigned MAX_ROWS        = dtp_pkg::DefMaxRows,
  parameter int unsigned MODERATORS      = dtp_pkg::DefModerators,
  parameter int unsigned CATEGORY_LEVELS = dtp_pkg::DefCategoryLevels,
  parameter int unsigned VALUE_BITS      = dtp_pkg::DefValueBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire dtp_pkg::in_t req_i,
  input  wire logic         cfg_we_i,
  input  wire logic [6:0]   cfg_wdata_i,
  output logic              valid_o,
  output dtp_pkg::out_t     result_o
);

  import dtp_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_ROWS);
  localparam int unsigned CL    = CATEGORY_LEVELS;
  localparam int unsigned VB    = VALUE_BITS;
  // Row word: parent, numeric flag, select, threshold, split mask, known mask
  localparam int unsigned RowW  = 7 + 1 + 2 + VB + 2 * CL;
  localparam int unsigned KnownLo  = 0;
  localparam int unsigned SplitLo  = CL;
  localparam int unsigned ThreshLo = 2 * CL;
  localparam int unsigned SelLo    = ThreshLo + VB;
  localparam int unsigned NumLo    = SelLo + 2;
  localparam int unsigned ParentLo = NumLo + 1;

  dtp_state_e state_q, state_d;
  logic [AddrW-1:0] row_q, row_d;
  logic [6:0] node_q, node_d;
  logic [6:0] row_count_q;
  logic [VB-1:0] vals_q [MODERATORS];
  logic valid_q, valid_d;
  out_t res_q, res_d;

  logic accept;
  logic [6:0] rows_eff;
  logic ram_we;
  logic [AddrW-1:0] raddr;
  logic [RowW-1:0] wdata, rdata;
  logic [31:0] in_vals [4];

  logic [6:0] r_parent;
  logic r_numeric;
  logic [1:0] r_sel;
  logic [VB-1:0] r_thresh;
  logic [15:0] r_split, r_known;
  logic [VB-1:0] v;
  logic [3:0] code;
  logic code_ok, greater, match, row_last;
  logic [6:0] child, next_node;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_RUN);

  // Clamp the row count to 1 .. MAX_ROWS
  always_comb begin
    if (row_count_q == 7'd0) begin
      rows_eff = 7'd1;
    end else if (row_count_q > 7'(MAX_ROWS)) begin
      rows_eff = 7'(MAX_ROWS);
    end else begin
      rows_eff = row_count_q;
    end
  end

  // Row memory: store on load requests, read the row after the current one
  assign ram_we = accept && (req_i.kind == KindLoad) && (7'(req_i.row_index) < 7'(MAX_ROWS));
  assign wdata  = {req_i.parent_node, req_i.numeric_split, req_i.moderator_select,
                   req_i.threshold[VB-1:0], req_i.split_categories[CL-1:0],
                   req_i.known_categories[CL-1:0]};
  assign raddr  = busy ? AddrW'(row_q + AddrW'(1)) : AddrW'(1);

  dtp_ram #(
    .WIDTH(RowW),
    .DEPTH(MAX_ROWS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.row_index[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Unpack the row under evaluation
  assign r_parent  = rdata[ParentLo +: 7];
  assign r_numeric = rdata[NumLo];
  assign r_sel     = rdata[SelLo +: 2];
  assign r_thresh  = rdata[ThreshLo +: VB];
  assign r_split   = 16'(rdata[SplitLo +: CL]);
  assign r_known   = 16'(rdata[KnownLo +: CL]);

  // Pick the tested moderator value
  always_comb begin
    v = '0;
    for (int i = 0; i < MODERATORS; i++) begin
      if (r_sel == 2'(i)) begin
        v = vals_q[i];
      end
    end
  end

  // Evaluate one split row
  assign code     = v[3:0];
  assign code_ok  = (5'(code) < 5'(CL)) && r_known[code];
  assign greater  = $signed(v) > $signed(r_thresh);
  assign match    = (node_q != NodeNa) && (node_q == r_parent);
  assign child    = 7'(row_q) << 1;
  assign row_last = (7'(row_q) == rows_eff - 7'd1);

  always_comb begin
    if (!match) begin
      next_node = node_q;
    end else if (r_numeric) begin
      next_node = child | 7'(greater);
    end else if (!code_ok) begin
      next_node = NodeNa;
    end else begin
      next_node = child | 7'(!r_split[code]);
    end
  end

  // Sequencer: next state and result
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    node_d  = node_q;
    valid_d = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.kind == KindPartition)) begin
          valid_d           = 1'b1;
          res_d.tree_row    = 6'd0;
          res_d.node_number = NodeRoot;
          res_d.last        = (rows_eff == 7'd1);
          node_d            = NodeRoot;
          row_d             = AddrW'(1);
          if (rows_eff != 7'd1) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        valid_d           = 1'b1;
        res_d.tree_row    = 6'(row_q);
        res_d.node_number = next_node;
        res_d.last        = row_last;
        node_d            = next_node;
        row_d             = AddrW'(row_q + AddrW'(1));
        if (row_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      node_q      <= NodeRoot;
      valid_q     <= 1'b0;
      row_count_q <= 7'd1;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      node_q  <= node_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        row_count_q <= cfg_wdata_i;
      end
    end
  end

  // Capture the observation values and hold the result
  assign in_vals[0] = req_i.value_a;
  assign in_vals[1] = req_i.value_b;
  assign in_vals[2] = req_i.value_c;
  assign in_vals[3] = req_i.value_d;

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept && (req_i.kind == KindPartition)) begin
      for (int i = 0; i < MODERATORS; i++) begin
        vals_q[i] <= in_vals[i][VB-1:0];
      end
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/dtp_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module dtp_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire dtp_pkg::in_t  req_i,
  input wire logic          valid_o,
  input wire dtp_pkg::out_t result_o
);

  import dtp_pkg::*;

  logic part_req;
  logic mid_walk;
  logic mid_na;
  logic root_shown;
  logic row_step;
  logic node_na;
  logic [5:0] prev_row_q;

  assign part_req   = start && !busy && (req_i.kind == KindPartition);
  assign mid_walk   = valid_o && !result_o.last;
  assign node_na    = (result_o.node_number == NodeNa);
  assign mid_na     = mid_walk && node_na;
  assign root_shown = valid_o && (result_o.tree_row == 6'd0) &&
                      (result_o.node_number == NodeRoot);
  assign row_step   = valid_o && (result_o.tree_row == 6'(prev_row_q + 6'd1));

  // Track the row shown in the previous cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_row_q <= '0;
    end else begin
      prev_row_q <= result_o.tree_row;
    end
  end

  // A partition request shows the root result next cycle
  `ASSERT_NEXT(a_root_first, clk_i, rst_ni, part_req, root_shown)

  // Rows of one walk come back to back in order
  `ASSERT_NEXT(a_rows_in_order, clk_i, rst_ni, mid_walk, row_step)

  // Busy is high while a row other than the final one is shown
  `ASSERT_SAME(a_busy_mid_walk, clk_i, rst_ni, mid_walk, busy)

  // An unknown category sticks for the rest of the walk
  `ASSERT_NEXT(a_na_sticks, clk_i, rst_ni, mid_na, node_na)

endmodule

bind decision_tree_partition dtp_checker u_dtp_checker (.*);

`default_nettype wire
